@@ hdl/fax_archive_record_chain_checker_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the archive record chain checker
// Checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FAX_ARCHIVE_RECORD_CHAIN_CHECKER_DEFINES_SVH
`define FAX_ARCHIVE_RECORD_CHAIN_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
`define FXA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define FXA_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define FXA_ASSERT(lbl, clk, rst, prop)
`define FXA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ hdl/fxarc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxarc_pkg
// Shared types and constants of the archive record chain checker.
// ----------------------------------------------------------------------------
package fxarc_pkg;

   localparam int HDR_BYTES  = 6;
   localparam int REC_BYTES  = 51;
   localparam int NAME_AT    = 4;
   localparam int NAME_BYTES = 13;

   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_SHORT    = 4'd1;
   localparam logic [3:0] ST_HEADER   = 4'd2;
   localparam logic [3:0] ST_TAG      = 4'd3;
   localparam logic [3:0] ST_RESERVED = 4'd4;
   localparam logic [3:0] ST_NEGATIVE = 4'd5;
   localparam logic [3:0] ST_SIZERULE = 4'd6;
   localparam logic [3:0] ST_METHOD   = 4'd7;
   localparam logic [3:0] ST_OVERRUN  = 4'd8;
   localparam logic [3:0] ST_PRELUDE  = 4'd9;
   localparam logic [3:0] ST_NAME     = 4'd10;
   localparam logic [3:0] ST_COUNT    = 4'd11;
   localparam logic [3:0] ST_TRUNC    = 4'd12;

   localparam logic [1:0] CSR_LENGTH = 2'd0;
   localparam logic [1:0] CSR_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_CAP    = 2'd2;

   localparam logic [15:0] METH_STORED  = 16'd1;
   localparam logic [15:0] METH_IMPLODE = 16'd2;
   localparam logic [15:0] METH_EMPTY   = 16'd6;

   localparam logic [31:0] HDR_MAGIC = 32'hFFFFF037;
   localparam logic [15:0] HDR_VER   = 16'h0300;
   localparam logic [31:0] TAG_LIVE  = 32'hFFFF037F;
   localparam logic [31:0] TAG_NULL  = 32'h00000000;

   typedef struct packed {
      logic       ok;
      logic [3:0] start;
      logic [3:0] len;
   } name_res_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  status;
      logic [15:0] member_index;
      logic [31:0] payload_offset;
      logic [30:0] packed_size;
      logic [30:0] full_size;
      logic [2:0]  method_code;
      logic [31:0] dos_stamp;
      logic [3:0]  name_start;
      logic [3:0]  name_length;
      logic        last;
   } rsp_type;

endpackage

@@ hdl/fxarc_name_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxarc_name_chk
// Checks the 13-byte 8.3 name field and finds the trimmed name span.
// ----------------------------------------------------------------------------
module fxarc_name_chk
   import fxarc_pkg::*;
(
   input  logic [12:0][7:0] name_bytes,
   output name_res_type     name_res
);

   function automatic logic bad_char(input logic [7:0] c);
      bad_char = (c < 8'h20) || (c > 8'h7E) || (c == 8'h2F) || (c == 8'h5C) ||
                 (c == 8'h3A) || (c == 8'h2A) || (c == 8'h3F) || (c == 8'h22) ||
                 (c == 8'h3C) || (c == 8'h3E) || (c == 8'h7C);
   endfunction

   logic       zero_found;
   logic       tail_ok;
   logic       chars_ok;
   logic [3:0] first_keep;
   logic [3:0] end_keep;
   logic [3:0] span;
   logic [7:0] c0;
   logic [7:0] c1;
   logic       dot_name;

   always_comb begin
      zero_found = 1'b0;
      tail_ok    = 1'b1;
      chars_ok   = 1'b1;
      end_keep   = 4'd0;
      first_keep = 4'd13;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (name_bytes[i] == 8'h00) begin
            zero_found = 1'b1;
         end else if (zero_found) begin
            tail_ok = 1'b0;
         end
         if (!zero_found) begin
            if (bad_char(name_bytes[i])) chars_ok = 1'b0;
            if (name_bytes[i] != 8'h20) end_keep = 4'(i + 1);
         end
      end
      for (int i = NAME_BYTES - 1; i >= 0; i--) begin
         if (name_bytes[i] != 8'h20) first_keep = 4'(i);
      end
      span = (end_keep > first_keep) ? end_keep - first_keep : 4'd0;
      c0 = (first_keep < 4'd13) ? name_bytes[first_keep] : 8'h00;
      c1 = (first_keep < 4'd12) ? name_bytes[first_keep + 4'd1] : 8'h00;
      // reject the current and parent directory names
      dot_name = ((span == 4'd1) && (c0 == 8'h2E)) ||
                 ((span == 4'd2) && (c0 == 8'h2E) && (c1 == 8'h2E));
      name_res.ok = (name_bytes[0] != 8'h00) && zero_found && tail_ok && chars_ok &&
                    (span != 4'd0) && !dot_name;
      name_res.start = name_res.ok ? first_keep : 4'd0;
      name_res.len   = name_res.ok ? span : 4'd0;
   end

endmodule

@@ hdl/fxarc_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxarc_parser
// Byte parser: header, record chain, payload skip and result generation.
// ----------------------------------------------------------------------------
module fxarc_parser
   import fxarc_pkg::*;
#(
   parameter int OFFSET_WIDTH = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        fire,
   input  logic [7:0]  data_byte,
   output logic        res0_v,
   output rsp_type     res0,
   output logic        res1_v,
   output rsp_type     res1
);

   localparam int W  = OFFSET_WIDTH;
   localparam int CW = (W + 1 > 32) ? W + 1 : 32;

   typedef enum logic [1:0] {PH_HEADER, PH_RECORD, PH_PAYLOAD, PH_DONE} phase_type;

   logic [31:0]       len_cfg_ff;
   logic [15:0]       limit_ff;
   logic [30:0]       cap_ff;
   logic [W-1:0]      pos_ff, pos_in;
   phase_type         phase_ff, phase_in;
   logic [5:0]        idx_ff, idx_in;
   logic [31:0]       remain_ff, remain_in;
   logic [16:0]       seen_ff, seen_in;
   logic [7:0]        pre_ff, pre_in;
   logic              pend_ff, pend_in;
   logic              failed_ff, failed_in;
   logic [7:0]        store_ff [REC_BYTES];

   logic [W+31:0]     len_wide;
   logic [W-1:0]      len;
   logic [W:0]        pos1, posm1, mem_off;
   logic [W+32:0]     off_wide;
   logic              active, wr_en;
   logic [3:0]        err, rec_err;
   logic              chain_end, mem_v, verd_v;
   logic [31:0]       plain, packed_sz, at, rem_dec;
   logic [15:0]       method;
   logic              hdr_ok, res_zero;
   logic [CW-1:0]     off_c, len_c, packed_c;
   logic [12:0][7:0]  name_bytes;
   name_res_type      name_res;
   rsp_type           mem_r, verd_r;

   always_comb begin
      for (int i = 0; i < NAME_BYTES; i++) name_bytes[i] = store_ff[NAME_AT + i];
   end

   fxarc_name_chk u_name (
      .name_bytes (name_bytes),
      .name_res   (name_res)
   );

   assign len_wide  = {{W{1'b0}}, len_cfg_ff};
   assign len       = len_wide[W-1:0];
   assign pos1      = {1'b0, pos_ff} + (W+1)'(1);
   assign posm1     = {1'b0, pos_ff} - (W+1)'(1);
   assign active    = fire && !failed_ff && (phase_ff != PH_DONE) && (pos_ff < len);
   assign plain     = {store_ff[22], store_ff[21], store_ff[20], store_ff[19]};
   assign packed_sz = {store_ff[26], store_ff[25], store_ff[24], store_ff[23]};
   assign method    = {store_ff[38], store_ff[37]};
   assign at        = packed_sz - remain_ff;
   assign rem_dec   = (remain_ff != 32'd0) ? remain_ff - 32'd1 : 32'd0;
   assign hdr_ok    = ({store_ff[3], store_ff[2], store_ff[1], store_ff[0]} == HDR_MAGIC) &&
                      ({data_byte, store_ff[4]} == HDR_VER);
   assign off_c     = CW'(pos1);
   assign len_c     = CW'(len);
   assign packed_c  = CW'(packed_sz);

   // record checks, with the incoming byte as the last reserved byte
   always_comb begin
      logic [31:0] tag;
      tag      = {store_ff[3], store_ff[2], store_ff[1], store_ff[0]};
      res_zero = (store_ff[17] == 8'h00) && (store_ff[18] == 8'h00) && (data_byte == 8'h00);
      for (int i = 39; i < REC_BYTES - 1; i++) begin
         if (store_ff[i] != 8'h00) res_zero = 1'b0;
      end
      rec_err = ST_OK;
      if ((tag != TAG_LIVE) && (tag != TAG_NULL)) begin
         rec_err = ST_TAG;
      end else if (!res_zero) begin
         rec_err = ST_RESERVED;
      end else if (plain[31] || packed_sz[31]) begin
         rec_err = ST_NEGATIVE;
      end else if (method == METH_STORED) begin
         if (packed_sz != plain) rec_err = ST_SIZERULE;
      end else if (method == METH_IMPLODE) begin
         if ((packed_sz < 32'd3) || (plain < 32'd1) || (plain > {1'b0, cap_ff}))
            rec_err = ST_SIZERULE;
      end else if (method == METH_EMPTY) begin
         if ((packed_sz != 32'd0) || (plain != 32'd0)) rec_err = ST_SIZERULE;
      end else begin
         rec_err = ST_METHOD;
      end
      if ((rec_err == ST_OK) && ((off_c > len_c) || (packed_c > len_c - off_c)))
         rec_err = ST_OVERRUN;
   end

   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      remain_in = remain_ff;
      pre_in    = pre_ff;
      pend_in   = pend_ff;
      failed_in = failed_ff;
      err       = ST_OK;
      chain_end = 1'b0;
      mem_v     = 1'b0;
      mem_off   = '0;
      wr_en     = 1'b0;
      verd_v    = 1'b0;
      seen_in   = seen_ff;
      if (active) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if ((pos_ff == '0) && (len < W'(HDR_BYTES + REC_BYTES))) begin
                  err = ST_SHORT;
               end else begin
                  wr_en = 1'b1;
                  if (idx_ff == 6'(HDR_BYTES - 1)) begin
                     idx_in = 6'd0;
                     if (!hdr_ok) err = ST_HEADER;
                     else phase_in = PH_RECORD;
                  end else begin
                     idx_in = idx_ff + 6'd1;
                  end
               end
            end
            PH_RECORD: begin
               if ((idx_ff == 6'd0) && (seen_ff >= {1'b0, limit_ff})) begin
                  err = ST_COUNT;
               end else if ((idx_ff == 6'd0) && ((len - pos_ff) < W'(REC_BYTES))) begin
                  err = ST_TRUNC;
               end else begin
                  wr_en = 1'b1;
                  if (idx_ff == 6'(REC_BYTES - 1)) begin
                     idx_in = 6'd0;
                     err    = rec_err;
                     if (rec_err == ST_OK) begin
                        remain_in = packed_sz;
                        if (method == METH_IMPLODE) begin
                           pend_in  = !name_res.ok;
                           phase_in = PH_PAYLOAD;
                        end else if (!name_res.ok) begin
                           err = ST_NAME;
                        end else begin
                           mem_v   = 1'b1;
                           mem_off = pos1;
                           seen_in = seen_ff + 17'd1;
                           if (packed_sz == 32'd0) chain_end = 1'b1;
                           else phase_in = PH_PAYLOAD;
                        end
                     end
                  end else begin
                     idx_in = idx_ff + 6'd1;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (method == METH_IMPLODE) begin
                  if (at == 32'd0) begin
                     pre_in = data_byte;
                  end else if (at == 32'd1) begin
                     if ((pre_ff > 8'd1) || (data_byte < 8'd4) || (data_byte > 8'd6))
                        err = ST_PRELUDE;
                     else if (pend_ff)
                        err = ST_NAME;
                     else begin
                        mem_v   = 1'b1;
                        mem_off = posm1;
                        seen_in = seen_ff + 17'd1;
                     end
                  end
               end
               if (err == ST_OK) begin
                  remain_in = rem_dec;
                  if (rem_dec == 32'd0) chain_end = 1'b1;
               end
            end
            default: ;
         endcase
         if (err != ST_OK) begin
            verd_v    = 1'b1;
            failed_in = 1'b1;
         end else if (chain_end) begin
            if (pos1 == {1'b0, len}) begin
               verd_v   = 1'b1;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_RECORD;
            end
         end
         pos_in = pos1[W-1:0];
      end
   end

   assign off_wide = {32'd0, mem_off};

   always_comb begin
      mem_r                = '0;
      mem_r.member_index   = seen_ff[15:0];
      mem_r.payload_offset = off_wide[31:0];
      mem_r.packed_size    = packed_sz[30:0];
      mem_r.full_size      = plain[30:0];
      mem_r.method_code    = store_ff[37][2:0];
      mem_r.dos_stamp      = {store_ff[34], store_ff[33], store_ff[32], store_ff[31]};
      mem_r.name_start     = name_res.start;
      mem_r.name_length    = name_res.len;
      mem_r.last           = !verd_v;
      verd_r               = '0;
      verd_r.kind          = 1'b1;
      verd_r.status        = err;
      verd_r.member_index  = seen_in[15:0];
      verd_r.last          = 1'b1;
      res0_v = mem_v || verd_v;
      res0   = mem_v ? mem_r : verd_r;
      res1_v = mem_v && verd_v;
      res1   = verd_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= 32'd0;
         limit_ff   <= 16'hFFFF;
         cap_ff     <= 31'h2000_0000;
         pos_ff     <= '0;
         phase_ff   <= PH_HEADER;
         idx_ff     <= 6'd0;
         remain_ff  <= 32'd0;
         seen_ff    <= 17'd0;
         pre_ff     <= 8'd0;
         pend_ff    <= 1'b0;
         failed_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LENGTH: len_cfg_ff <= csr_wdata;
               CSR_LIMIT:  limit_ff   <= csr_wdata[15:0];
               CSR_CAP:    cap_ff     <= csr_wdata[30:0];
               default: ;
            endcase
         end
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         remain_ff <= remain_in;
         seen_ff   <= seen_in;
         pre_ff    <= pre_in;
         pend_ff   <= pend_in;
         failed_ff <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) store_ff[idx_ff] <= data_byte;
   end

endmodule

@@ hdl/fxarc_rsp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxarc_rsp_fifo
// Four-entry result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
`include "fax_archive_record_chain_checker_defines.svh"
module fxarc_rsp_fifo
   import fxarc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push0,
   input  rsp_type din0,
   input  logic    push1,
   input  rsp_type din1,
   output logic    room2,
   output logic    out_valid,
   output rsp_type dout,
   input  logic    out_ready
);

   rsp_type    mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 3'd0);
   assign dout      = mem_ff[rd_ff];
   assign room2     = (count_ff <= 3'd2);

   always_comb begin
      count_in = count_ff + 3'(push0) + 3'(push1) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 2'd0;
         rd_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wr_ff    <= wr_ff + 2'(push0) + 2'(push1);
         rd_ff    <= rd_ff + 2'(pop);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) mem_ff[wr_ff] <= din0;
      if (push1) mem_ff[wr_ff + 2'd1] <= din1;
   end

   `FXA_ASSERT(a_count_bound, clock, reset, count_ff <= 3'd4)
   `FXA_ASSERT(a_no_overfill, clock, reset, (push0 || push1) |-> (count_ff <= 3'd2))
   `FXA_ASSERT(a_drain, clock, reset, (pop && !push0 && !push1) |=> (count_ff == $past(count_ff) - 3'd1))
   `FXA_ASSERT_NR(a_reset_empty, clock, reset |=> (count_ff == 3'd0))

endmodule

@@ hdl/fax_archive_record_chain_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fax_archive_record_chain_checker
// Streams an archive one byte per transaction and checks its record chain.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : archive bytes in file order, one byte per transaction.
//   rsp_*  : results; tuser is the kind (0 member, 1 verdict), tlast marks
//            the last result caused by one byte.
//   csr_*  : write stream length (0), member limit (1), implode size cap (2)
//            while the block is idle.
// A byte is parsed in the cycle it is accepted; its results (zero, one or
// two) are written into the result queue, which drives rsp_tvalid. One byte per cycle is taken
// as long as the four-entry result queue has room for two results.
// When the receiver stalls, results wait in the queue and req_tready falls
// once fewer than two entries are free.
// Reset clears the parser to the header phase, empties the queue and
// loads the register defaults (length 0, limit 65535, cap 2^29).
// After any error verdict or the final verdict, bytes are accepted and
// dropped until the next reset.
// ----------------------------------------------------------------------------
module fax_archive_record_chain_checker
   import fxarc_pkg::*;
#(
   parameter int OFFSET_WIDTH = 32
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, member_index, payload_offset, packed_size, full_size,
   // method_code, dos_stamp, name_start, name_length, zero pad
   output logic [159:0] rsp_tdata,
   output logic         rsp_tuser,   // kind
   output logic         rsp_tlast    // last
);

   logic    fire;
   logic    res0_v, res1_v, room2;
   rsp_type res0, res1, head;

   assign fire       = req_tvalid && req_tready;
   assign req_tready = room2;

   fxarc_parser #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .data_byte (req_tdata),
      .res0_v    (res0_v),
      .res0      (res0),
      .res1_v    (res1_v),
      .res1      (res1)
   );

   fxarc_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push0     (res0_v),
      .din0      (res0),
      .push1     (res1_v),
      .din1      (res1),
      .room2     (room2),
      .out_valid (rsp_tvalid),
      .dout      (head),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {3'd0, head.name_length, head.name_start, head.dos_stamp,
                       head.method_code, head.full_size, head.packed_size,
                       head.payload_offset, head.member_index, head.status};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
